/* src/dfa_pkg.sv */
// ---------------------------------------------------------------------------
// dfa_pkg
// Shared widths, command and register codes, and the search link type of the
// table-driven word acceptor.
// ---------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

  // Default sizing of the automaton
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_SYMBOLS_DEF = 16;

  // Fixed field widths
  localparam int CHAR_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int STATE_W = 4;
  localparam int COUNT_W = 5;
  localparam int MASK_W  = 16;
  localparam int CMD_W   = 2;

  // Alphabet slots are limited by the slot field
  localparam int SLOT_LIMIT = 16;

  // Command codes (carried in tuser)
  localparam logic [CMD_W-1:0] CMD_LOAD_ALPHA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WORD_CHAR  = 2'd2;

  // Configuration register indexes
  localparam logic REG_SYMBOL_COUNT = 1'b0;
  localparam logic REG_ACCEPT_MASK  = 1'b1;

  // Search link handed from one alphabet cell to the next
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } link_t;

endpackage

`default_nettype wire

/* src/dfa_sym_cell.sv */
// ---------------------------------------------------------------------------
// dfa_sym_cell
// One alphabet slot: holds its character byte, compares it to the probe and
// passes the lowest matching slot on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module dfa_sym_cell (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [dfa_pkg::CHAR_W-1:0] wr_char,
  input  wire                        in_use,
  input  wire  [dfa_pkg::SLOT_W-1:0] cell_idx,
  input  wire  [dfa_pkg::CHAR_W-1:0] probe_char,
  input  wire  dfa_pkg::link_t       link_in,
  output dfa_pkg::link_t             link_out
);

  logic [dfa_pkg::CHAR_W-1:0] char_r;
  logic                       match;

  // Slot byte, written by an alphabet load
  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_r <= wr_char;
    end
  end

  // Lowest slot wins: an upstream hit passes through untouched
  assign match = in_use && (char_r == probe_char);

  always_comb begin
    link_out.hit  = link_in.hit | match;
    link_out.slot = link_in.hit ? link_in.slot : cell_idx;
  end

endmodule

`default_nettype wire

/* src/dfa_trans_mem.sv */
// ---------------------------------------------------------------------------
// dfa_trans_mem
// Transition table: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module dfa_trans_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 4
) (
  input  wire           clk,
  input  wire           wr_en,
  input  wire  [AW-1:0] wr_addr,
  input  wire  [DW-1:0] wr_data,
  input  wire           rd_en,
  input  wire  [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/dfa_word_acceptor.sv */
// ---------------------------------------------------------------------------
// dfa_word_acceptor
// Table-driven DFA word checker: alphabet search over a row of slot cells,
// next state from a transition table memory, one result per word.
// ---------------------------------------------------------------------------
// Load commands are taken back to back while no word character is in flight.
// A word character does not overlap the next: the alphabet search and table
// read are issued on acceptance and the state updates when the read data
// returns; in_tready stays low until then, as the next read needs that state.
// A word's result is registered when the lookup of its last character
// completes; while an earlier result still waits, that character holds.
// Synchronous active-low reset clears state, flags and registers
// (symbol_count = 1, accept_mask = 0); alphabet and table are not cleared.
`default_nettype none

module dfa_word_acceptor #(
  parameter int MAX_STATES  = dfa_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = dfa_pkg::MAX_SYMBOLS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,  // symbol_char[7:0], symbol_slot[11:8],
                                 // from_state[15:12], to_state[19:16], zero pad
  input  wire  [1:0]  in_tuser,  // command
  input  wire         in_tlast,  // last_symbol
  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata, // word_valid[0], accepted[1], final_state[5:2],
                                 // zero pad
  // Configuration
  input  wire         cfg_wr_en,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_wdata
);

  localparam int NCELL = (MAX_SYMBOLS < dfa_pkg::SLOT_LIMIT) ? MAX_SYMBOLS
                                                             : dfa_pkg::SLOT_LIMIT;
  localparam int DEPTH = MAX_SYMBOLS * MAX_STATES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Input field unpacking
  logic [dfa_pkg::CHAR_W-1:0]  f_char;
  logic [dfa_pkg::SLOT_W-1:0]  f_slot;
  logic [dfa_pkg::STATE_W-1:0] f_from;
  logic [dfa_pkg::STATE_W-1:0] f_to;

  assign f_char = in_tdata[7:0];
  assign f_slot = in_tdata[11:8];
  assign f_from = in_tdata[15:12];
  assign f_to   = in_tdata[19:16];

  // Registers
  logic                          busy_r;
  logic                          hit_r;
  logic                          last_r;
  logic [dfa_pkg::STATE_W-1:0]   state_r;
  logic                          bad_r;
  logic                          out_valid_r;
  logic [5:0]                    out_data_r;
  logic [dfa_pkg::COUNT_W-1:0]   symbol_count_r;
  logic [dfa_pkg::MASK_W-1:0]    accept_mask_r;

  logic                          in_fire;
  logic                          word_fire;
  logic                          done;
  logic [dfa_pkg::STATE_W-1:0]   state_nxt;
  logic                          bad_nxt;
  logic [dfa_pkg::STATE_W-1:0]   rd_data;
  logic [31:0]                   rd_addr_wide;
  logic [31:0]                   wr_addr_wide;
  logic                          trans_we;
  logic [dfa_pkg::STATE_W-1:0]   fs;
  logic                          word_ok;

  dfa_pkg::link_t links [NCELL+1];

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign word_fire = in_fire && (in_tuser == dfa_pkg::CMD_WORD_CHAR);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= dfa_pkg::COUNT_W'(1);
      accept_mask_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dfa_pkg::REG_SYMBOL_COUNT: symbol_count_r <= cfg_wdata[dfa_pkg::COUNT_W-1:0];
        dfa_pkg::REG_ACCEPT_MASK:  accept_mask_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Alphabet cell row: lowest in-use matching slot ripples down the chain
  assign links[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    dfa_sym_cell u_cell (
      .clk        (clk),
      .wr_en      (in_fire && (in_tuser == dfa_pkg::CMD_LOAD_ALPHA) &&
                   (f_slot == dfa_pkg::SLOT_W'(i))),
      .wr_char    (f_char),
      .in_use     (dfa_pkg::COUNT_W'(i) < symbol_count_r),
      .cell_idx   (dfa_pkg::SLOT_W'(i)),
      .probe_char (f_char),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  // Table addresses: slot-major, state-minor
  assign rd_addr_wide = 32'(links[NCELL].slot) * 32'(MAX_STATES) + 32'(state_r);
  assign wr_addr_wide = 32'(f_slot) * 32'(MAX_STATES) + 32'(f_from);
  assign trans_we     = in_fire && (in_tuser == dfa_pkg::CMD_LOAD_TRANS) &&
                        (32'(f_slot) < 32'(MAX_SYMBOLS)) &&
                        (32'(f_from) < 32'(MAX_STATES)) &&
                        (32'(f_to) < 32'(MAX_STATES));

  dfa_trans_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (dfa_pkg::STATE_W)
  ) u_trans_mem (
    .clk     (clk),
    .wr_en   (trans_we),
    .wr_addr (wr_addr_wide[AW-1:0]),
    .wr_data (f_to),
    .rd_en   (word_fire),
    .rd_addr (rd_addr_wide[AW-1:0]),
    .rd_data (rd_data)
  );

  // Once the table read returns: step the state; a last character waits for
  // the result register to free up
  assign state_nxt = hit_r ? rd_data : state_r;
  assign bad_nxt   = bad_r | !hit_r;
  assign done      = busy_r && (!last_r || !out_valid_r || out_tready);
  assign word_ok   = !bad_nxt;
  assign fs        = word_ok ? state_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      state_r <= '0;
      bad_r   <= 1'b0;
    end else if (word_fire) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
      if (last_r) begin
        state_r <= '0;
        bad_r   <= 1'b0;
      end else begin
        state_r <= state_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

  // Search outcome of the character in flight
  always_ff @(posedge clk) begin
    if (word_fire) begin
      hit_r  <= links[NCELL].hit;
      last_r <= in_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && last_r) begin
      out_data_r <= {fs, word_ok && accept_mask_r[fs], word_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  // Checks
  a_word_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    done && last_r |=> (state_r == '0) && !bad_r)
    else $error("state not cleared after end of word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[0] |-> (out_data_r[5:1] == '0))
    else $error("invalid word carries nonzero state or accept");

  a_char_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    word_fire |=> busy_r)
    else $error("word character did not start a lookup");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && last_r && out_valid_r && !out_tready |=> busy_r && out_valid_r)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* sim/tb_dfa_word_acceptor.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dfa_word_acceptor
// Self-checking bench for the table-driven word acceptor. A small checker
// class tracks the alphabet, the transition table, the walk state and the
// registers, and predicts one verdict per word. Loads and word characters go
// in over the input stream. Verdicts are compared field by field as they leave.
// ---------------------------------------------------------------------------

module tb_dfa_word_acceptor;

  // Command code that the block ignores
  localparam logic [dfa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One word verdict as the block reports it
  typedef struct packed {
    logic                        valid;
    logic                        accepted;
    logic [dfa_pkg::STATE_W-1:0] fstate;
  } verdict_t;

  // -------------------------------------------------------------------------
  // Word checker: shadow automaton plus the queue of verdicts still owed
  // -------------------------------------------------------------------------
  class word_checker;
    logic [dfa_pkg::CHAR_W-1:0]  alpha [dfa_pkg::SLOT_LIMIT];
    logic [dfa_pkg::STATE_W-1:0] next_of [dfa_pkg::SLOT_LIMIT][16];
    bit                          next_ok [dfa_pkg::SLOT_LIMIT][16];
    logic [dfa_pkg::STATE_W-1:0] state_now;
    bit                          stray_seen;
    logic [dfa_pkg::COUNT_W-1:0] count_reg;
    logic [dfa_pkg::MASK_W-1:0]  accept_bits;
    verdict_t                    verdicts [$];
    int                          errors;

    function new();
      state_now   = '0;
      stray_seen  = 1'b0;
      count_reg   = 5'd1;
      accept_bits = '0;
      errors      = 0;
      foreach (next_ok[s, q]) next_ok[s][q] = 1'b0;
    endfunction

    function void write_reg(input logic idx, input logic [15:0] val);
      if (idx == dfa_pkg::REG_SYMBOL_COUNT) count_reg = val[dfa_pkg::COUNT_W-1:0];
      else accept_bits = val;
    endfunction

    // Slots searched; counts above the slot limit saturate
    function int live_slots();
      return (count_reg > dfa_pkg::SLOT_LIMIT) ? dfa_pkg::SLOT_LIMIT : int'(count_reg);
    endfunction

    // Lowest matching slot in use, -1 when the byte is outside the alphabet
    function int slot_of(input logic [dfa_pkg::CHAR_W-1:0] ch);
      for (int s = 0; s < live_slots(); s++)
        if (alpha[s] == ch) return s;
      return -1;
    endfunction

    // Apply one accepted input transaction
    function void apply_item(input logic [dfa_pkg::CMD_W-1:0] cmd, input logic [7:0] ch,
                             input logic [3:0] slot, input logic [3:0] from_q,
                             input logic [3:0] to_q, input logic last);
      verdict_t v;
      int       s;
      case (cmd)
        dfa_pkg::CMD_LOAD_ALPHA: alpha[slot] = ch;
        dfa_pkg::CMD_LOAD_TRANS: begin
          next_of[slot][from_q] = to_q;
          next_ok[slot][from_q] = 1'b1;
        end
        dfa_pkg::CMD_WORD_CHAR: begin
          s = slot_of(ch);
          if (s < 0) stray_seen = 1'b1;
          else state_now = next_of[s][state_now];
          if (last) begin
            v.valid    = !stray_seen;
            v.fstate   = v.valid ? state_now : '0;
            v.accepted = v.valid && accept_bits[v.fstate];
            verdicts.push_back(v);
            state_now  = '0;
            stray_seen = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    task flag(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Compare one result transaction with the oldest verdict owed
    task check_result(input logic [7:0] data);
      verdict_t want;
      if (verdicts.size() == 0) begin
        flag($sformatf("result %h with no word pending", data));
        return;
      end
      want = verdicts.pop_front();
      if (data[0] !== want.valid)
        flag($sformatf("word_valid %b, want %b", data[0], want.valid));
      if (data[1] !== want.accepted)
        flag($sformatf("accepted %b, want %b", data[1], want.accepted));
      if (data[5:2] !== want.fstate)
        flag($sformatf("final_state %0d, want %0d", data[5:2], want.fstate));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Signals and block
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // symbol_char, symbol_slot, from_state, to_state
  logic [1:0]  in_tuser = '0;   // command
  logic        in_tlast = 1'b0; // last_symbol
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // word_valid, accepted, final_state
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  word_checker book = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_orders = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fed = 0;

  dfa_word_acceptor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_orders != hold_seen) begin
      hold_seen  <= hold_orders;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tdata);
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driving tasks
  // -------------------------------------------------------------------------
  // Offer one input transaction and hold it until accepted
  task automatic send_item(input logic [dfa_pkg::CMD_W-1:0] cmd, input logic [7:0] ch,
                           input logic [3:0] slot, input logic [3:0] from_q,
                           input logic [3:0] to_q, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, to_q, from_q, slot, ch};
    in_tuser  <= cmd;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.apply_item(cmd, ch, slot, from_q, to_q, last);
    if (cmd != CMD_UNUSED) fed++;
  endtask

  // Stop offering, drain every verdict, then let a character in flight finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers; only called once the block is idle
  task automatic write_regs(input logic [4:0] count, input logic [15:0] mask);
    cfg_wr_en <= 1'b1;
    cfg_index <= dfa_pkg::REG_SYMBOL_COUNT;
    cfg_wdata <= {11'h0, count};
    @(posedge clk);
    cfg_index <= dfa_pkg::REG_ACCEPT_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.write_reg(dfa_pkg::REG_SYMBOL_COUNT, {11'h0, count});
    book.write_reg(dfa_pkg::REG_ACCEPT_MASK, mask);
    @(posedge clk);
  endtask

  // Mostly bytes from the live alphabet, sometimes any byte
  function automatic logic [7:0] pick_char();
    int n;
    n = book.live_slots();
    if (n > 0 && $urandom_range(99) < 85) return book.alpha[$urandom_range(n - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [4:0] pick_count();
    case ($urandom_range(5))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // One word with random loads and noise mixed in. A transition that the walk
  // is about to use gets loaded first if it was never written.
  task automatic send_word();
    int          len;
    int          s;
    logic [7:0]  ch;
    len = ($urandom_range(19) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(24))
        0: send_item(dfa_pkg::CMD_LOAD_ALPHA, 8'($urandom_range(255)),
                     4'($urandom_range(15)), 4'($urandom_range(15)),
                     4'($urandom_range(15)), 1'($urandom_range(1)));
        1, 2: send_item(dfa_pkg::CMD_LOAD_TRANS, 8'($urandom_range(255)),
                        4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 1'($urandom_range(1)));
        3: send_item(CMD_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)),
                     4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)));
        default: ;
      endcase
      ch = pick_char();
      s  = book.slot_of(ch);
      if (s >= 0 && !book.next_ok[s][book.state_now])
        send_item(dfa_pkg::CMD_LOAD_TRANS, 8'($urandom_range(255)), 4'(s), book.state_now,
                  4'($urandom_range(15)), 1'($urandom_range(1)));
      send_item(dfa_pkg::CMD_WORD_CHAR, ch, 4'($urandom_range(15)), 4'($urandom_range(15)),
                4'($urandom_range(15)), i == len - 1);
    end
  endtask

  task automatic run_words(input int unsigned n);
    int unsigned goal;
    goal = fed + n;
    while (fed < goal) send_word();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [4:0]  count;
    logic [15:0] mask;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: states 0 and 15 accepting, one live slot
    write_regs(5'd1, 16'h8001);
    send_item(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);               // ignored command
    send_item(dfa_pkg::CMD_LOAD_ALPHA, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);  // last mark on a load
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'hFF, 4'h0, 4'h0, 4'h0, 1'b1);   // outside the alphabet
    send_item(dfa_pkg::CMD_LOAD_TRANS, 8'h00, 4'h0, 4'h0, 4'hF, 1'b0);
    send_item(dfa_pkg::CMD_LOAD_TRANS, 8'h00, 4'h0, 4'hF, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);   // back to state 0
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);   // ends in state 15
    // Bad character in mid-word poisons the whole word
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h7F, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);
    // Duplicate byte in slot 1 with a different transition; slot 0 must win
    send_item(dfa_pkg::CMD_LOAD_ALPHA, 8'h00, 4'h1, 4'h0, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_LOAD_TRANS, 8'hFF, 4'h1, 4'h0, 4'h3, 1'b1);
    send_item(dfa_pkg::CMD_LOAD_ALPHA, 8'hA5, 4'hF, 4'h0, 4'h0, 1'b0);
    send_item(dfa_pkg::CMD_LOAD_TRANS, 8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);
    settle();
    write_regs(5'd2, 16'h0008);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);
    // No live slots: every character is outside the alphabet
    settle();
    write_regs(5'd0, 16'hFFFF);
    send_item(dfa_pkg::CMD_WORD_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b1);
    settle();

    // Random part: fill every alphabet slot so any count is safe to search
    tx_idle_pct = 19;
    rx_idle_pct = 59;
    for (int s = 0; s < dfa_pkg::SLOT_LIMIT; s++)
      send_item(dfa_pkg::CMD_LOAD_ALPHA, 8'($urandom_range(255)), 4'(s),
                4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 19; rx_idle_pct = 59; end
        1: begin tx_idle_pct = 59; rx_idle_pct = 19; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        count = pick_count();
        mask  = pick_mask();
        if (blk == 0) begin
          case (ph)
            0: begin count = 5'd16; mask = 16'h0000; end
            1: begin count = 5'd31; mask = 16'hFFFF; end
            default: count = 5'd1;
          endcase
        end
        settle();
        write_regs(count, mask);
        // Long receiver hold-off while the sender keeps offering
        if (ph == 2 && blk == 0) hold_orders <= hold_orders + 1;
        if (ph == 1 && blk == 1) begin
          run_words(76);
          settle();
          run_words(76);
        end else begin
          run_words(152);
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (book.verdicts.size() != 0) book.flag("verdicts left over at the end");
    if (book.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
